// ----- rtl/tlpts_pkg.sv -----
// Package with shared types and constants for the two-level priority tick scheduler.
`default_nettype none
package tlpts_pkg;
    localparam int SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int TW = 16;
    localparam int CNT_W = 4;
    localparam logic [7:0] ORDER_LIMIT = 8'd100;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic CFG_LOW_COUNT = 1'b0;
    localparam logic CFG_HIGH_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic        queue_sel;
        logic [2:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  order;
    } in_item_t;

    typedef struct packed {
        logic [15:0] time_now;
        logic        idle;
        logic        ran_high;
        logic [2:0]  ran_slot;
        logic        finished_now;
        logic        all_done;
        logic [15:0] waiting_time;
        logic [15:0] response_time;
        logic [15:0] turnaround_time;
        logic        entry_done;
    } out_item_t;

    // Best candidate travelling along the chain.
    typedef struct packed {
        logic              found;
        logic [7:0]        order;
        logic [SLOT_W-1:0] slot;
    } cand_t;

    // Command broadcast to every cell; each cell's copy gets its own sel_hit.
    typedef struct packed {
        logic              load;
        logic              run;
        logic              wait_en;
        logic              sel_hit;
        logic [TW-1:0]     now;
        logic [TW-1:0]     arrival;
        logic [TW-1:0]     burst;
        logic [7:0]        order;
    } cell_cmd_t;

    typedef struct packed {
        logic          eligible;
        logic          done;
        logic          finished;
        logic          finished_now;
        logic [TW-1:0] waiting;
        logic [TW-1:0] response;
        logic [TW-1:0] turnaround;
    } cell_stat_t;
endpackage
`default_nettype wire

// ----- rtl/tlpts_cell.sv -----
// One scheduler entry: stored fields, statistics and one link of the selection chain.
`default_nettype none
module tlpts_cell (
    input  wire                   clk,
    input  wire                   in_use,
    input  wire [tlpts_pkg::SLOT_W-1:0] my_slot,
    input  tlpts_pkg::cell_cmd_t  cmd,
    input  tlpts_pkg::cand_t      cand_in,
    output tlpts_pkg::cand_t      cand_out,
    output tlpts_pkg::cell_stat_t stat
);
    import tlpts_pkg::*;

    logic [TW-1:0] arrival_reg, burst_reg, remaining_reg, waiting_reg;
    logic [TW-1:0] response_reg, turnaround_reg;
    logic [7:0]    order_reg;
    logic          finished_reg;
    logic          elig;

    assign elig = in_use && (arrival_reg <= cmd.now) && !finished_reg;

    always_comb
    begin
        cand_out = cand_in;
        if (elig && order_reg <= ORDER_LIMIT &&
            (!cand_in.found || order_reg <= cand_in.order))
        begin
            cand_out.found = 1'b1;
            cand_out.order = order_reg;
            cand_out.slot  = my_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && cmd.sel_hit)
        begin
            arrival_reg    <= cmd.arrival;
            burst_reg      <= cmd.burst;
            order_reg      <= cmd.order;
            remaining_reg  <= cmd.burst;
            waiting_reg    <= '0;
            response_reg   <= '0;
            turnaround_reg <= '0;
            finished_reg   <= 1'b0;
        end
        else if (cmd.run && cmd.sel_hit)
        begin
            if (burst_reg == remaining_reg)
                response_reg <= cmd.now - arrival_reg;
            if (remaining_reg <= TW'(1))
            begin
                remaining_reg  <= '0;
                turnaround_reg <= cmd.now + TW'(1) - arrival_reg;
                finished_reg   <= 1'b1;
            end
            else
                remaining_reg <= remaining_reg - TW'(1);
        end
        else if (cmd.wait_en && elig && waiting_reg != '1)
            waiting_reg <= waiting_reg + TW'(1);
    end

    assign stat.eligible     = elig;
    assign stat.done         = !in_use || finished_reg;
    assign stat.finished     = finished_reg;
    assign stat.finished_now = remaining_reg <= TW'(1);
    assign stat.waiting      = waiting_reg;
    assign stat.response     = response_reg;
    assign stat.turnaround   = turnaround_reg;
endmodule
`default_nettype wire

// ----- rtl/tlpts_queue.sv -----
// One queue: a row of cells with the candidate passed from cell to cell.
`default_nettype none
module tlpts_queue (
    input  wire                    clk,
    input  wire [tlpts_pkg::CNT_W-1:0] count,
    input  tlpts_pkg::cell_cmd_t   cmd,
    input  wire [tlpts_pkg::SLOT_W-1:0] sel_slot,
    output tlpts_pkg::cand_t       best,
    output logic                   done,
    output logic [tlpts_pkg::SLOTS-1:0] done_bits,
    output tlpts_pkg::cell_stat_t  sel_stat
);
    import tlpts_pkg::*;

    cand_t      chain [SLOTS+1];
    cell_stat_t stats [SLOTS];

    assign chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        cell_cmd_t c;
        always_comb
        begin
            c = cmd;
            c.sel_hit = (sel_slot == SLOT_W'(i));
        end
        tlpts_cell u_cell (
            .clk(clk),
            .in_use(CNT_W'(i) < count),
            .my_slot(SLOT_W'(i)),
            .cmd(c),
            .cand_in(chain[i]),
            .cand_out(chain[i+1]),
            .stat(stats[i])
        );
        assign done_bits[i] = stats[i].done;
    end

    assign best     = chain[SLOTS];
    assign done     = &done_bits;
    assign sel_stat = stats[sel_slot];
endmodule
`default_nettype wire

// ----- rtl/two_level_priority_tick_scheduler.sv -----
// Top level of the two-level priority tick scheduler.
//
//  Channel  Signals                         Direction
//  in       in_valid, in_stall, in_item     into block
//  out      out_valid, out_stall, out_item  out of block
//  cfg      cfg_we, cfg_index, cfg_data     into block
//
// A tick or read item passes through the accept cycle, an execute cycle in which both
// candidates ripple through the cell chains and the entries update, and the cycle in
// which the result is offered. A load or an unused mode ends after its execute cycle.
// The result waits in an output register; the next item is taken once it has left.
// Reset clears the tick count, the counts and the handshake state; entries are not reset.
// A stalled result holds; the input stays stalled until it leaves.
`default_nettype none
module two_level_priority_tick_scheduler (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  tlpts_pkg::in_item_t     in_item,
    output logic                    out_valid,
    input  wire                     out_stall,
    output tlpts_pkg::out_item_t    out_item,
    input  wire                     cfg_we,
    input  wire                     cfg_index,
    input  wire [3:0]               cfg_data
);
    import tlpts_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;

    logic [1:0]   state_reg, state_next;
    in_item_t     item_reg;
    logic [TW-1:0] tick_reg;
    logic [CNT_W-1:0] low_cnt_reg, high_cnt_reg, low_use, high_use;
    out_item_t    out_reg, out_next;
    logic         out_valid_reg;

    cell_cmd_t cmd_lo, cmd_hi;
    cand_t     best_lo, best_hi;
    logic      done_lo, done_hi;
    logic [SLOTS-1:0] done_bits_lo, done_bits_hi;
    cell_stat_t st_lo, st_hi;
    logic      exec, is_tick, all_done_pre, run_hi, run_lo;

    assign low_use  = (low_cnt_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : low_cnt_reg;
    assign high_use = (high_cnt_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : high_cnt_reg;

    assign exec    = (state_reg == ST_EXEC);
    assign is_tick = exec && item_reg.mode == MODE_TICK;
    assign all_done_pre = done_lo && done_hi;
    assign run_hi  = is_tick && !all_done_pre && best_hi.found;
    assign run_lo  = is_tick && !all_done_pre && !best_hi.found && best_lo.found;

    always_comb
    begin
        cmd_lo = '0;
        cmd_lo.now     = tick_reg;
        cmd_lo.arrival = item_reg.arrival;
        cmd_lo.burst   = item_reg.burst;
        cmd_lo.order   = item_reg.order;
        cmd_hi = cmd_lo;
        cmd_lo.load = exec && item_reg.mode == MODE_LOAD && !item_reg.queue_sel;
        cmd_hi.load = exec && item_reg.mode == MODE_LOAD && item_reg.queue_sel;
        cmd_lo.run  = run_lo;
        cmd_hi.run  = run_hi;
        cmd_lo.wait_en = run_lo || run_hi;
        cmd_hi.wait_en = run_hi;
    end

    logic [SLOT_W-1:0] sel_lo, sel_hi;
    assign sel_lo = (item_reg.mode == MODE_TICK) ? best_lo.slot : item_reg.slot;
    assign sel_hi = (item_reg.mode == MODE_TICK) ? best_hi.slot : item_reg.slot;

    tlpts_queue u_lo (
        .clk(clk), .count(low_use), .cmd(cmd_lo), .sel_slot(sel_lo),
        .best(best_lo), .done(done_lo), .done_bits(done_bits_lo), .sel_stat(st_lo)
    );
    tlpts_queue u_hi (
        .clk(clk), .count(high_use), .cmd(cmd_hi), .sel_slot(sel_hi),
        .best(best_hi), .done(done_hi), .done_bits(done_bits_hi), .sel_stat(st_hi)
    );

    // All-done after this tick: the running entry may be the last one open.
    logic done_after;
    always_comb
    begin
        done_after = all_done_pre;
        if (run_hi && st_hi.finished_now)
            done_after = done_lo &&
                         ((done_bits_hi | (SLOTS'(1) << best_hi.slot)) == '1);
        else if (run_lo && st_lo.finished_now)
            done_after = done_hi &&
                         ((done_bits_lo | (SLOTS'(1) << best_lo.slot)) == '1);
    end

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid && !in_stall) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            low_cnt_reg   <= '0;
            high_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_LOW_COUNT)  low_cnt_reg  <= cfg_data;
            if (cfg_we && cfg_index == CFG_HIGH_COUNT) high_cnt_reg <= cfg_data;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (exec && (item_reg.mode == MODE_TICK || item_reg.mode == MODE_READ))
                out_valid_reg <= 1'b1;
            if (is_tick && !all_done_pre)
                tick_reg <= tick_reg + TW'(1);
        end
    end

    always_comb
    begin
        out_next = '0;
        out_next.time_now = tick_reg;
        if (item_reg.mode == MODE_READ)
        begin
            out_next.all_done = all_done_pre;
            if (item_reg.queue_sel)
            begin
                out_next.waiting_time    = st_hi.waiting;
                out_next.response_time   = st_hi.response;
                out_next.turnaround_time = st_hi.turnaround;
                out_next.entry_done      = st_hi.finished;
            end
            else
            begin
                out_next.waiting_time    = st_lo.waiting;
                out_next.response_time   = st_lo.response;
                out_next.turnaround_time = st_lo.turnaround;
                out_next.entry_done      = st_lo.finished;
            end
        end
        else
        begin
            out_next.all_done     = done_after;
            out_next.idle         = !(run_hi || run_lo);
            out_next.ran_high     = run_hi;
            out_next.ran_slot     = run_hi ? best_hi.slot : (run_lo ? best_lo.slot : '0);
            out_next.finished_now = run_hi ? st_hi.finished_now :
                                    (run_lo ? st_lo.finished_now : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_item;
        if (exec)
            out_reg <= out_next;
    end

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> state_reg == ST_IDLE) else $error("exec lasted more than one cycle");
    a_no_dual_run: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_hi && run_lo)) else $error("both queues ran");
    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (run_hi || run_lo) |=> tick_reg == $past(tick_reg) + TW'(1))
        else $error("tick count did not advance");
endmodule
`default_nettype wire

// ----- verif/two_level_priority_tick_scheduler_tb.sv -----
// Self-checking testbench for the two-level priority tick scheduler with a predictor.
`default_nettype none
module two_level_priority_tick_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tlpts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_LOW_COUNT;
    logic [3:0] cfg_data = '0;

    in_item_t stim_items[$];
    out_item_t report_queue[$];
    int send_idle_pct = 12;
    int recv_stall_pct = 49;
    int error_count = 0;
    int cycle_count = 0;

    // Scheduler state mirrored for prediction.
    logic [3:0] low_cnt_q = '0;
    logic [3:0] high_cnt_q = '0;
    logic [15:0] tick_now = '0;
    logic [15:0] ent_arrival[2][SLOTS];
    logic [15:0] ent_burst[2][SLOTS];
    logic [7:0] ent_order[2][SLOTS];
    logic [15:0] ent_remaining[2][SLOTS];
    logic [15:0] ent_waiting[2][SLOTS];
    logic [15:0] ent_response[2][SLOTS];
    logic [15:0] ent_turnaround[2][SLOTS];
    logic ent_finished[2][SLOTS];

    two_level_priority_tick_scheduler u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int slots_in_use(int q);
        logic [3:0] c;
        c = q ? high_cnt_q : low_cnt_q;
        return (c > SLOTS) ? SLOTS : int'(c);
    endfunction

    function automatic bit is_ready(int q, int s);
        return ent_arrival[q][s] <= tick_now && !ent_finished[q][s];
    endfunction

    function automatic int choose_slot(int q);
        int best;
        int r;
        best = ORDER_LIMIT;
        r = -1;
        for (int s = 0; s < slots_in_use(q); s++)
        begin
            if (is_ready(q, s) && ent_order[q][s] <= best)
            begin
                best = ent_order[q][s];
                r = s;
            end
        end
        return r;
    endfunction

    function automatic bit all_finished();
        for (int q = 0; q < 2; q++)
        begin
            for (int s = 0; s < slots_in_use(q); s++)
            begin
                if (!ent_finished[q][s])
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void charge_waiting(int q, int skip);
        for (int s = 0; s < slots_in_use(q); s++)
        begin
            if (s != skip && is_ready(q, s) && ent_waiting[q][s] != 16'hFFFF)
            begin
                ent_waiting[q][s] = ent_waiting[q][s] + 16'd1;
            end
        end
    endfunction

    function automatic bit serve_entry(int q, int s);
        if (ent_burst[q][s] == ent_remaining[q][s])
        begin
            ent_response[q][s] = tick_now - ent_arrival[q][s];
        end
        if (ent_remaining[q][s] <= 16'd1)
        begin
            ent_remaining[q][s] = '0;
            ent_turnaround[q][s] = tick_now + 16'd1 - ent_arrival[q][s];
            ent_finished[q][s] = 1'b1;
            return 1'b1;
        end
        ent_remaining[q][s] = ent_remaining[q][s] - 16'd1;
        return 1'b0;
    endfunction

    function automatic void schedule_item(in_item_t it);
        out_item_t r;
        int q;
        int s;
        int lo;
        int hi;
        q = it.queue_sel;
        s = it.slot;
        r = '0;
        if (it.mode == MODE_LOAD)
        begin
            ent_arrival[q][s] = it.arrival;
            ent_burst[q][s] = it.burst;
            ent_order[q][s] = it.order;
            ent_remaining[q][s] = it.burst;
            ent_waiting[q][s] = '0;
            ent_response[q][s] = '0;
            ent_turnaround[q][s] = '0;
            ent_finished[q][s] = 1'b0;
            return;
        end
        if (it.mode != MODE_TICK && it.mode != MODE_READ)
        begin
            return;
        end
        r.time_now = tick_now;
        if (it.mode == MODE_READ)
        begin
            r.waiting_time = ent_waiting[q][s];
            r.response_time = ent_response[q][s];
            r.turnaround_time = ent_turnaround[q][s];
            r.entry_done = ent_finished[q][s];
            r.all_done = all_finished();
        end
        else if (all_finished())
        begin
            r.idle = 1'b1;
            r.all_done = 1'b1;
        end
        else
        begin
            lo = choose_slot(0);
            hi = choose_slot(1);
            if (hi >= 0)
            begin
                r.ran_high = 1'b1;
                r.ran_slot = hi[2:0];
                r.finished_now = serve_entry(1, hi);
                charge_waiting(1, hi);
                charge_waiting(0, -1);
            end
            else if (lo >= 0)
            begin
                r.ran_slot = lo[2:0];
                r.finished_now = serve_entry(0, lo);
                charge_waiting(0, lo);
            end
            else
            begin
                r.idle = 1'b1;
            end
            tick_now = tick_now + 16'd1;
            r.all_done = all_finished();
        end
        report_queue.push_back(r);
    endfunction

    function automatic in_item_t make_item(logic [1:0] mode, int q, int s, int arr, int bur,
                                           int ord);
        in_item_t it;
        it.mode = mode;
        it.queue_sel = q[0];
        it.slot = s[2:0];
        it.arrival = arr[15:0];
        it.burst = bur[15:0];
        it.order = ord[7:0];
        return it;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                schedule_item(in_item);
            end
            if (!in_valid || !in_stall)
            begin
                if (stim_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_item <= stim_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (out_valid && !out_stall)
            begin
                if (report_queue.size() == 0)
                begin
                    $error("unexpected result item %p", out_item);
                    error_count++;
                end
                else
                begin
                    exp_r = report_queue.pop_front();
                    if (out_item.time_now !== exp_r.time_now)
                    begin
                        $error("time_now expected %0d actual %0d", exp_r.time_now,
                               out_item.time_now);
                        error_count++;
                    end
                    if (out_item.idle !== exp_r.idle)
                    begin
                        $error("idle expected %0d actual %0d", exp_r.idle, out_item.idle);
                        error_count++;
                    end
                    if (out_item.ran_high !== exp_r.ran_high)
                    begin
                        $error("ran_high expected %0d actual %0d", exp_r.ran_high,
                               out_item.ran_high);
                        error_count++;
                    end
                    if (out_item.ran_slot !== exp_r.ran_slot)
                    begin
                        $error("ran_slot expected %0d actual %0d", exp_r.ran_slot,
                               out_item.ran_slot);
                        error_count++;
                    end
                    if (out_item.finished_now !== exp_r.finished_now)
                    begin
                        $error("finished_now expected %0d actual %0d", exp_r.finished_now,
                               out_item.finished_now);
                        error_count++;
                    end
                    if (out_item.all_done !== exp_r.all_done)
                    begin
                        $error("all_done expected %0d actual %0d", exp_r.all_done,
                               out_item.all_done);
                        error_count++;
                    end
                    if (out_item.waiting_time !== exp_r.waiting_time)
                    begin
                        $error("waiting_time expected %0d actual %0d", exp_r.waiting_time,
                               out_item.waiting_time);
                        error_count++;
                    end
                    if (out_item.response_time !== exp_r.response_time)
                    begin
                        $error("response_time expected %0d actual %0d", exp_r.response_time,
                               out_item.response_time);
                        error_count++;
                    end
                    if (out_item.turnaround_time !== exp_r.turnaround_time)
                    begin
                        $error("turnaround_time expected %0d actual %0d",
                               exp_r.turnaround_time, out_item.turnaround_time);
                        error_count++;
                    end
                    if (out_item.entry_done !== exp_r.entry_done)
                    begin
                        $error("entry_done expected %0d actual %0d", exp_r.entry_done,
                               out_item.entry_done);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic wait_quiet();
        while (stim_items.size() > 0 || in_valid || report_queue.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_counts(logic [3:0] lc, logic [3:0] hc);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_LOW_COUNT;
        cfg_data <= lc;
        @(posedge clk);
        cfg_index <= CFG_HIGH_COUNT;
        cfg_data <= hc;
        @(posedge clk);
        cfg_we <= 1'b0;
        low_cnt_q = lc;
        high_cnt_q = hc;
    endtask

    function automatic in_item_t random_load(int q, int s);
        int arr;
        int bur;
        int ord;
        int pick;
        arr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                          : int'(tick_now) + $urandom_range(0, 15);
        pick = $urandom_range(0, 99);
        bur = (pick < 85) ? $urandom_range(1, 6) : (pick < 90) ? 0 : $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        ord = (pick < 40) ? $urandom_range(0, 3) : (pick < 80) ? $urandom_range(0, 100)
                                                               : $urandom_range(101, 255);
        return make_item(MODE_LOAD, q, s, arr, bur, ord);
    endfunction

    initial
    begin
        int pick;
        logic [3:0] lc;
        logic [3:0] hc;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_counts(4'd8, 4'd2);
        for (int s = 0; s < SLOTS; s++)
        begin
            case (s)
                0: stim_items.push_back(make_item(MODE_LOAD, 0, s, 0, 1, 0));
                1: stim_items.push_back(make_item(MODE_LOAD, 0, s, 0, 0, 0));
                2: stim_items.push_back(make_item(MODE_LOAD, 0, s, 65535, 65535, 255));
                default: stim_items.push_back(make_item(MODE_LOAD, 0, s, 0, 3, 50));
            endcase
        end
        stim_items.push_back(make_item(MODE_LOAD, 1, 0, 2, 1, 100));
        stim_items.push_back(make_item(MODE_LOAD, 1, 1, 1, 65535, 101));
        for (int s = 2; s < SLOTS; s++)
        begin
            stim_items.push_back(make_item(MODE_LOAD, 1, s, 0, 1, 0));
        end
        repeat (6) stim_items.push_back(make_item(MODE_TICK, 0, 0, 0, 0, 0));
        stim_items.push_back(make_item(MODE_READ, 0, 1, 0, 0, 0));
        stim_items.push_back(make_item(MODE_READ, 1, 0, 0, 0, 0));
        stim_items.push_back(make_item(MODE_UNUSED, 1, 7, 65535, 65535, 255));
        wait_quiet();

        for (int phase = 0; phase < 30; phase++)
        begin
            if (phase < 10)
            begin
                send_idle_pct = 12;
                recv_stall_pct = 49;
            end
            else if (phase < 20)
            begin
                send_idle_pct = 49;
                recv_stall_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            case (phase)
                0: begin lc = 4'd0; hc = 4'd0; end
                1: begin lc = 4'd8; hc = 4'd8; end
                2: begin lc = 4'd15; hc = 4'd15; end
                default:
                begin
                    lc = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 8));
                    hc = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 8));
                end
            endcase
            write_counts(lc, hc);
            for (int q = 0; q < 2; q++)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    stim_items.push_back(random_load(q, s));
                end
            end
            for (int n = 0; n < 44; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    stim_items.push_back(make_item(MODE_TICK, $urandom_range(0, 1),
                        $urandom_range(0, 7), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 255)));
                end
                else if (pick < 90)
                begin
                    stim_items.push_back(make_item(MODE_READ, $urandom_range(0, 1),
                        $urandom_range(0, 7), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 255)));
                end
                else if (pick < 95)
                begin
                    stim_items.push_back(random_load($urandom_range(0, 1), $urandom_range(0, 7)));
                end
                else
                begin
                    stim_items.push_back(make_item(MODE_UNUSED, $urandom_range(0, 1),
                        $urandom_range(0, 7), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 255)));
                end
            end
            wait_quiet();
        end

        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
